// ===== rtl/envf_pkg.sv =====
// Shared types and constants for the attack/release envelope follower.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package envf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int ENV_W    = 32;   // Q16.16 envelope
    localparam int CH_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 16;

    typedef logic [CH_W-1:0]     t_ch;
    typedef logic [ENV_W-1:0]    t_env;
    typedef logic [COEF_W-1:0]   t_coef;
    typedef logic [SAMPLE_W-1:0] t_mag;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_RESET  = 1'b1
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 1'b1;

    // Write-side control from the item stage into the channel store.
    typedef struct packed {
        logic upd;   // store a new envelope and clear the reload mark
        logic arm;   // set the reload mark of every channel
        t_env env;
    } t_store_wr;

endpackage

`default_nettype wire

// ===== rtl/envf_smooth.sv =====
// One-pole attack/release update of a single channel's envelope.
// Purely combinational; uses types from envf_pkg.
`default_nettype none

module envf_smooth (
    input  logic signed [envf_pkg::SAMPLE_W-1:0] i_sample,
    input  envf_pkg::t_env                       i_env,
    input  logic                                 i_reload,
    input  envf_pkg::t_coef                      i_attack_coef,
    input  envf_pkg::t_coef                      i_release_coef,
    output envf_pkg::t_env                       o_next_env
);
    import envf_pkg::*;

    t_mag                    mag;
    t_env                    x;
    logic                    rising;
    logic                    env_ge;
    t_coef                   coef;
    t_env                    diff;
    logic [COEF_W+ENV_W-1:0] prod;
    t_env                    step;

    // The magnitude of the most negative sample is 0x8000, which still fits.
    assign mag    = i_sample[SAMPLE_W-1] ? (t_mag'(~i_sample) + t_mag'(1)) : t_mag'(i_sample);
    assign x      = {mag, {(ENV_W-SAMPLE_W){1'b0}}};
    assign rising = (x >= i_env);
    assign env_ge = (i_env >= x);
    assign coef   = rising ? i_attack_coef : i_release_coef;
    assign diff   = env_ge ? (i_env - x) : (x - i_env);
    assign prod   = (COEF_W+ENV_W)'(coef) * (COEF_W+ENV_W)'(diff);
    assign step   = prod[COEF_W+ENV_W-1:COEF_W];

    always_comb begin
        if (i_reload) begin
            o_next_env = x;
        end else if (env_ge) begin
            o_next_env = x + step;
        end else begin
            o_next_env = x - step;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/envf_chstore.sv =====
// Per-channel state: Q16.16 envelopes with valid bits, and reload marks.
// Depends on envf_pkg for the write control struct.
`default_nettype none

module envf_chstore #(
    parameter int CHANNELS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  envf_pkg::t_ch         i_ch,
    input  envf_pkg::t_store_wr   i_wr,
    output logic                  o_hit,
    output envf_pkg::t_env        o_env,
    output logic                  o_reload
);
    import envf_pkg::*;

    // Channels the 4-bit channel field can reach.
    localparam int DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_env             r_env [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_reload;
    logic [IDX_W-1:0] idx;

    assign idx      = i_ch[IDX_W-1:0];
    assign o_hit    = (32'(i_ch) < DEPTH);
    // An entry never written since reset reads as zero.
    assign o_env    = (o_hit && r_vld[idx]) ? r_env[idx] : '0;
    assign o_reload = o_hit && r_reload[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_reload <= '0;
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                if (i_wr.arm) begin
                    r_reload[k] <= 1'b1;
                end else if (i_wr.upd && (i_ch == t_ch'(k))) begin
                    r_reload[k] <= 1'b0;
                    r_vld[k]    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_wr.upd && (i_ch == t_ch'(k))) begin
                r_env[k] <= i_wr.env;
            end
        end
    end

    a_arm_sets_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.arm |=> (&r_reload))
        else $error("reload marks not all set after a reset request");

    a_upd_clears_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.upd && o_hit) |=> (r_vld[$past(idx)] && !r_reload[$past(idx)]))
        else $error("updated channel not valid or still marked for reload");

    a_upd_stores_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.upd && o_hit) |=> (r_env[$past(idx)] == $past(i_wr.env)))
        else $error("updated channel does not hold the new envelope");

endmodule

`default_nettype wire

// ===== rtl/attack_release_envelope_follower.sv =====
// Top level of the multichannel attack/release envelope follower.
// Instantiates envf_chstore and envf_smooth; depends on envf_pkg.
//
// The block takes one transaction per clock while o_stall is low. The input register
// holds an accepted transaction; one pass through the store read, one 16x32 multiply
// and one add then fills the result register when it is empty or being drained, which
// sets the clock limit. A reset request takes a slot but gives no result, and neither
// does a sample on a channel at or above CHANNELS. The user is to write coefficients
// through the configuration port only while the block is idle; the block itself does
// not enforce it. Index 0 is the attack coefficient and index 1 the release coefficient.
`default_nettype none

module attack_release_envelope_follower #(
    parameter int CHANNELS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [envf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [envf_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_opcode,
    input  logic signed [envf_pkg::SAMPLE_W-1:0]  i_sample,
    input  envf_pkg::t_ch                         i_channel,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [envf_pkg::SAMPLE_W-1:0]         o_envelope,
    output envf_pkg::t_ch                         o_out_channel
);
    import envf_pkg::*;

    t_coef                       r_attack_coef;
    t_coef                       r_release_coef;

    logic                        r_in_valid;
    logic                        r_in_opcode;
    logic signed [SAMPLE_W-1:0]  r_in_sample;
    t_ch                         r_in_channel;

    logic                        r_out_valid;
    logic [SAMPLE_W-1:0]         r_out_env;
    t_ch                         r_out_ch;

    logic                        advance;
    logic                        fire;
    logic                        is_reset;
    logic                        hit;
    logic                        reload;
    t_env                        env_cur;
    t_env                        n_env;
    t_store_wr                   store_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_coef  <= '0;
            r_release_coef <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ATTACK:  r_attack_coef  <= i_cfg_data;
                REG_RELEASE: r_release_coef <= i_cfg_data;
            endcase
        end
    end

    // The result register can load when it is empty or being drained.
    assign advance  = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !advance;
    assign fire     = r_in_valid && advance;
    assign is_reset = (r_in_opcode == OP_RESET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_opcode  <= i_opcode;
            r_in_sample  <= i_sample;
            r_in_channel <= i_channel;
        end
    end

    envf_chstore #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ch     (r_in_channel),
        .i_wr     (store_wr),
        .o_hit    (hit),
        .o_env    (env_cur),
        .o_reload (reload)
    );

    envf_smooth u_smooth (
        .i_sample       (r_in_sample),
        .i_env          (env_cur),
        .i_reload       (reload),
        .i_attack_coef  (r_attack_coef),
        .i_release_coef (r_release_coef),
        .o_next_env     (n_env)
    );

    assign store_wr.upd = fire && !is_reset && hit;
    assign store_wr.arm = fire && is_reset;
    assign store_wr.env = n_env;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= store_wr.upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_wr.upd) begin
            r_out_env <= n_env[ENV_W-1:ENV_W-SAMPLE_W];
            r_out_ch  <= r_in_channel;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_envelope    = r_out_env;
    assign o_out_channel = r_out_ch;

endmodule

`default_nettype wire
